FILE: rtl/core/wsam_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the wildcard shift-and matcher.
package wsam_pkg;

	localparam int PATTERN_BITS_DEF = 64;
	localparam int ALPHABET_SIZE    = 256;
	localparam int ADDR_W           = $clog2(ALPHABET_SIZE);
	localparam int POS_W            = 32;

	localparam logic [7:0] STAR_BYTE  = 8'h2A;
	localparam logic [7:0] QMARK_BYTE = 8'h3F;
	localparam logic [7:0] UPPER_A    = 8'h41;
	localparam logic [7:0] UPPER_Z    = 8'h5A;
	localparam logic [7:0] CASE_DIFF  = 8'h20;

	typedef enum logic [2:0] {
		CMD_BEGIN_PAT    = 3'd0,
		CMD_PAT_BYTE     = 3'd1,
		CMD_END_PAT      = 3'd2,
		CMD_BEGIN_SEARCH = 3'd3,
		CMD_TEXT         = 3'd4
	} cmd_t;

	typedef struct packed {
		logic [2:0]       cmd;
		logic [7:0]       byte_value;
		logic [POS_W-1:0] start_position;
		logic             is_last;
	} item_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] match_position;
		logic [POS_W-1:0] match_length;
	} result_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic              clear_all;
	} mask_ctl_t;

	// Letters share one table entry: the table is indexed by the lower-case form.
	function automatic logic [7:0] fold_lower(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= UPPER_A && c <= UPPER_Z) begin
			r = c + CASE_DIFF;
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/wsam_in_if.sv
`timescale 1ns / 1ps
// Input item channel: command, byte, start position, last flag.
interface wsam_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [7:0]  byte_value;
	logic [31:0] start_position;
	logic        is_last;

	modport source(output valid, output cmd, output byte_value, output start_position,
		output is_last, input ready);
	modport sink(input valid, input cmd, input byte_value, input start_position,
		input is_last, output ready);
endinterface

FILE: rtl/core/wsam_out_if.sv
`timescale 1ns / 1ps
// Result item channel: found flag, match position and length.
interface wsam_out_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [31:0] match_position;
	logic [31:0] match_length;

	modport source(output valid, output found, output match_position,
		output match_length, input ready);
	modport sink(input valid, input found, input match_position,
		input match_length, output ready);
endinterface

FILE: rtl/core/wsam_mask_store.sv
`timescale 1ns / 1ps
// Character mask memory with per-entry valid bits and write-to-read forwarding.
module wsam_mask_store #(
	parameter int DATA_W = wsam_pkg::PATTERN_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [wsam_pkg::ADDR_W-1:0] rd_addr,
	input  wsam_pkg::mask_ctl_t       ctl,
	input  logic [DATA_W-1:0]         wr_data,
	output logic [DATA_W-1:0]         rd_data
);
	import wsam_pkg::*;

	logic [DATA_W-1:0]        mem [ALPHABET_SIZE];
	logic [ALPHABET_SIZE-1:0] valid_q;
	logic [DATA_W-1:0]        rd_q;
	logic [DATA_W-1:0]        fwd_data_q;
	logic                     fwd_q;
	logic [ADDR_W-1:0]        addr_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			fwd_data_q <= wr_data;
			addr_q     <= rd_addr;
		end
	end

	// Read and write of the same entry in one cycle: take the new data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= ctl.wr_en && (ctl.wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.clear_all) begin
			valid_q <= '0;
		end else if (ctl.wr_en) begin
			valid_q[ctl.wr_addr] <= 1'b1;
		end
	end

	always_comb begin
		if (!valid_q[addr_q]) begin
			rd_data = '1;
		end else if (fwd_q) begin
			rd_data = fwd_data_q;
		end else begin
			rd_data = rd_q;
		end
	end

endmodule

FILE: rtl/core/wsam_engine.sv
`timescale 1ns / 1ps
// Execute stage: pattern loading, shift-and step and match reporting.
module wsam_engine #(
	parameter int PATTERN_BITS = wsam_pkg::PATTERN_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    fire,
	input  wsam_pkg::item_t         item,
	input  logic [PATTERN_BITS-1:0] mask_rd,
	output wsam_pkg::mask_ctl_t     mask_ctl,
	output logic [PATTERN_BITS-1:0] mask_wr,
	output logic                    res_valid,
	output wsam_pkg::result_t       res
);
	import wsam_pkg::*;

	localparam int NB_W = $clog2(PATTERN_BITS + 1);
	localparam logic [PATTERN_BITS-1:0] ONE_V = PATTERN_BITS'(1);

	logic [PATTERN_BITS-1:0] end_bits_q, end_bits_d;
	logic [PATTERN_BITS-1:0] qmark_q, qmark_d;
	logic [NB_W-1:0]         next_bit_q, next_bit_d;
	logic                    prev_lit_q, prev_lit_d;
	logic [PATTERN_BITS-1:0] mv_q, mv_d;
	logic [PATTERN_BITS-1:0] pend_q, pend_d;
	logic [PATTERN_BITS-1:0] gate_q, gate_d;
	logic [POS_W-1:0]        pos_q, pos_d;
	logic [POS_W-1:0]        run_q, run_d;
	logic                    active_q, active_d;

	logic [PATTERN_BITS-1:0] bit_vec, end_vec, mask_eff, mv_step, hit, done_v, gate_new;
	logic [POS_W-1:0]        run_new;
	logic                    pat_full;

	always_comb begin
		bit_vec  = ONE_V << next_bit_q;
		end_vec  = ONE_V << (next_bit_q - NB_W'(1));
		pat_full = next_bit_q >= NB_W'(PATTERN_BITS);
		mask_eff = mask_rd & ~qmark_q;
		mv_step  = ((mv_q << 1) | mask_eff) & gate_q;
		hit      = mv_step & pend_q;
		done_v   = hit ^ pend_q;
		// Block carries from completed segments into the following ones.
		gate_new = ~((done_v << 1) - ONE_V);
		run_new  = (mv_step == ~ONE_V) ? pos_q : run_q;
	end

	always_comb begin
		end_bits_d = end_bits_q;
		qmark_d    = qmark_q;
		next_bit_d = next_bit_q;
		prev_lit_d = prev_lit_q;
		mv_d       = mv_q;
		pend_d     = pend_q;
		gate_d     = gate_q;
		pos_d      = pos_q;
		run_d      = run_q;
		active_d   = active_q;
		mask_ctl   = '0;
		mask_wr    = mask_rd & ~bit_vec;
		res_valid  = 1'b0;
		res        = '0;
		if (fire) begin
			case (cmd_t'(item.cmd))
				CMD_BEGIN_PAT: begin
					active_d           = 1'b0;
					end_bits_d         = '0;
					qmark_d            = '0;
					next_bit_d         = '0;
					prev_lit_d         = 1'b0;
					mask_ctl.clear_all = 1'b1;
				end
				CMD_PAT_BYTE: begin
					active_d = 1'b0;
					if (item.byte_value == STAR_BYTE) begin
						if (prev_lit_q && next_bit_q != '0) begin
							end_bits_d = end_bits_q | end_vec;
						end
						prev_lit_d = 1'b0;
					end else if (pat_full) begin
						prev_lit_d = 1'b0;
					end else begin
						if (item.byte_value == QMARK_BYTE) begin
							qmark_d = qmark_q | bit_vec;
						end else begin
							mask_ctl.wr_en   = 1'b1;
							mask_ctl.wr_addr = fold_lower(item.byte_value);
						end
						next_bit_d = next_bit_q + NB_W'(1);
						prev_lit_d = 1'b1;
					end
				end
				CMD_END_PAT: begin
					active_d = 1'b0;
					if (prev_lit_q && next_bit_q != '0) begin
						end_bits_d = end_bits_q | end_vec;
					end
					prev_lit_d = 1'b0;
				end
				CMD_BEGIN_SEARCH: begin
					mv_d     = '1;
					pend_d   = end_bits_q;
					gate_d   = '1;
					pos_d    = item.start_position;
					run_d    = '0;
					active_d = 1'b1;
				end
				CMD_TEXT: begin
					if (active_q) begin
						mv_d  = mv_step;
						run_d = run_new;
						if (hit != pend_q && hit == '0) begin
							res_valid          = 1'b1;
							res.found          = 1'b1;
							res.match_position = run_new;
							res.match_length   = pos_q - run_new + POS_W'(1);
							active_d           = 1'b0;
						end else begin
							if (hit != pend_q) begin
								gate_d = gate_new;
								pend_d = pend_q & ~done_v;
							end
							pos_d = pos_q + POS_W'(1);
							if (item.is_last) begin
								res_valid = 1'b1;
								active_d  = 1'b0;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_bits_q <= '0;
			qmark_q    <= '0;
			next_bit_q <= '0;
			prev_lit_q <= 1'b0;
			mv_q       <= '1;
			pend_q     <= '0;
			gate_q     <= '1;
			pos_q      <= '0;
			run_q      <= '0;
			active_q   <= 1'b0;
		end else begin
			end_bits_q <= end_bits_d;
			qmark_q    <= qmark_d;
			next_bit_q <= next_bit_d;
			prev_lit_q <= prev_lit_d;
			mv_q       <= mv_d;
			pend_q     <= pend_d;
			gate_q     <= gate_d;
			pos_q      <= pos_d;
			run_q      <= run_d;
			active_q   <= active_d;
		end
	end

endmodule

FILE: rtl/core/wildcard_shift_and_matcher.sv
`timescale 1ns / 1ps
// Case-insensitive wildcard matcher (shift-and), top level.
// Usage: one input channel carries command items: begin pattern, pattern byte,
// end pattern, begin search (with start position) and text byte (with a last
// flag). '*' splits segments, '?' matches any byte. Text bytes after a begin
// search step the match vector; the block emits one result item when all
// segments have matched (found, start position, length) or, if the byte
// flagged last passes without a match, a not-found item with zero fields.
// Timing: one item is accepted per cycle while no waiting result stalls the
// pipeline. Each item reads the character mask memory in its accept cycle and
// executes in the engine once the output register is free; its result item is
// presented from the output register. Back-to-back writes and reads of
// one mask entry are forwarded. The single output register lets a new item in
// while a result waits; a stalled receiver holds the result and then the pipeline.
// Reset: asynchronous, clears the pattern, search state and all mask valid
// bits at once (no clearing pass); the block accepts items right after it.
module wildcard_shift_and_matcher #(
	parameter int PATTERN_BITS = wsam_pkg::PATTERN_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	wsam_in_if.sink   in_ch,
	wsam_out_if.source out_ch
);
	import wsam_pkg::*;

	logic                    accept, out_free, s1_fire;
	logic                    s1_valid_q;
	item_t                   item_s1;
	logic [PATTERN_BITS-1:0] mask_rd, mask_wr;
	mask_ctl_t               mask_ctl;
	logic                    res_valid;
	result_t                 res;
	logic                    out_valid_q;
	result_t                 out_q;

	assign out_free     = !out_valid_q || out_ch.ready;
	assign s1_fire      = s1_valid_q && out_free;
	assign in_ch.ready  = !s1_valid_q || out_free;
	assign accept       = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.cmd            <= in_ch.cmd;
			item_s1.byte_value     <= in_ch.byte_value;
			item_s1.start_position <= in_ch.start_position;
			item_s1.is_last        <= in_ch.is_last;
		end
	end

	wsam_mask_store #(
		.DATA_W(PATTERN_BITS)
	) u_mask_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (fold_lower(in_ch.byte_value)),
		.ctl     (mask_ctl),
		.wr_data (mask_wr),
		.rd_data (mask_rd)
	);

	wsam_engine #(
		.PATTERN_BITS(PATTERN_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (s1_fire),
		.item      (item_s1),
		.mask_rd   (mask_rd),
		.mask_ctl  (mask_ctl),
		.mask_wr   (mask_wr),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && res_valid) begin
			out_q <= res;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.found          = out_q.found;
	assign out_ch.match_position = out_q.match_position;
	assign out_ch.match_length   = out_q.match_length;

endmodule

FILE: tb/wsam_match_checker.sv
`timescale 1ns / 1ps
// Watches both channels of the wildcard matcher, predicts each result and compares it.
module wsam_match_checker (
	input  logic clk,
	input  logic arst_n,
	wsam_in_if   in_ch,
	wsam_out_if  out_ch,
	output int   mismatches,
	output int   outstanding
);
	import wsam_pkg::*;

	localparam int PAT_BITS = PATTERN_BITS_DEF;

	// predicted block state
	logic [63:0] mask_tbl [ALPHABET_SIZE];
	logic [63:0] seg_ends;
	logic [6:0]  pat_bit;
	logic        last_lit;
	logic [63:0] mvec;
	logic [63:0] open_ends;
	logic [63:0] gate;
	logic [31:0] pos;
	logic [31:0] run_pos;
	logic        searching;

	result_t expected_results[$];

	function automatic logic [7:0] lower_of(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
	endfunction

	function automatic logic [7:0] upper_of(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
	endfunction

	task automatic wipe_pattern();
		for (int i = 0; i < ALPHABET_SIZE; i++) begin
			mask_tbl[i] = '1;
		end
		seg_ends = '0;
		pat_bit  = '0;
		last_lit = 1'b0;
	endtask

	task automatic close_seg();
		if (last_lit && pat_bit > 0 && pat_bit <= 64) begin
			seg_ends[pat_bit - 7'd1] = 1'b1;
		end
		last_lit = 1'b0;
	endtask

	task automatic load_pat_byte(input logic [7:0] b);
		if (b == STAR_BYTE) begin
			close_seg();
		end else if (pat_bit >= PAT_BITS) begin
			// bits past the end: dropped, and the segment loses its end bit
			last_lit = 1'b0;
		end else begin
			if (b == QMARK_BYTE) begin
				for (int i = 0; i < ALPHABET_SIZE; i++) begin
					mask_tbl[i][pat_bit] = 1'b0;
				end
			end else begin
				mask_tbl[lower_of(b)][pat_bit] = 1'b0;
				mask_tbl[upper_of(b)][pat_bit] = 1'b0;
			end
			pat_bit  = pat_bit + 7'd1;
			last_lit = 1'b1;
		end
	endtask

	task automatic step_text(input logic [7:0] b, input logic last);
		logic [63:0] hit;
		logic [63:0] done;
		result_t     res;
		mvec = ((mvec << 1) | mask_tbl[b]) & gate;
		if (mvec == ~64'd1) begin
			run_pos = pos;
		end
		hit = mvec & open_ends;
		if (hit != open_ends) begin
			if (hit == '0) begin
				res.found          = 1'b1;
				res.match_position = run_pos;
				res.match_length   = pos - run_pos + 32'd1;
				expected_results.push_back(res);
				searching = 1'b0;
				return;
			end
			done      = hit ^ open_ends;
			gate      = ~((done << 1) - 64'd1);
			open_ends = open_ends & ~done;
		end
		pos = pos + 32'd1;
		if (last) begin
			res = '0;
			expected_results.push_back(res);
			searching = 1'b0;
		end
	endtask

	task automatic apply_item(input item_t it);
		case (it.cmd)
			CMD_BEGIN_PAT: begin
				searching = 1'b0;
				wipe_pattern();
			end
			CMD_PAT_BYTE: begin
				searching = 1'b0;
				load_pat_byte(it.byte_value);
			end
			CMD_END_PAT: begin
				searching = 1'b0;
				close_seg();
			end
			CMD_BEGIN_SEARCH: begin
				mvec      = '1;
				open_ends = seg_ends;
				gate      = '1;
				pos       = it.start_position;
				run_pos   = '0;
				searching = 1'b1;
			end
			CMD_TEXT: begin
				if (searching) begin
					step_text(it.byte_value, it.is_last);
				end
			end
			default: ;
		endcase
	endtask

	initial begin
		wipe_pattern();
		mvec        = '1;
		open_ends   = '0;
		gate        = '1;
		pos         = '0;
		run_pos     = '0;
		searching   = 1'b0;
		mismatches  = 0;
		outstanding = 0;
	end

	always @(posedge clk) begin
		item_t   it;
		result_t want;
		if (arst_n) begin
			// an output item always comes from an earlier input, so compare first
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("found: unexpected result, actual %0d", out_ch.found);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (out_ch.found !== want.found) begin
						$error("found: expected %0d, actual %0d", want.found, out_ch.found);
						mismatches++;
					end
					if (out_ch.match_position !== want.match_position) begin
						$error("match_position: expected %0h, actual %0h",
							want.match_position, out_ch.match_position);
						mismatches++;
					end
					if (out_ch.match_length !== want.match_length) begin
						$error("match_length: expected %0h, actual %0h",
							want.match_length, out_ch.match_length);
						mismatches++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				it.cmd            = in_ch.cmd;
				it.byte_value     = in_ch.byte_value;
				it.start_position = in_ch.start_position;
				it.is_last        = in_ch.is_last;
				apply_item(it);
			end
			outstanding = expected_results.size();
		end
	end

endmodule

FILE: tb/wildcard_shift_and_matcher_test.sv
`timescale 1ns / 1ps
// Stimulus, receiver stalls and verdict for the wildcard shift-and matcher.
module wildcard_shift_and_matcher_test;
	import wsam_pkg::*;

	localparam int         ITEM_TARGET   = 1850;
	localparam int         CYCLE_LIMIT   = 400000;
	localparam int         HOLD_CYCLES   = 400;
	localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
	localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   sent_count;
	int   burst_left;
	bit   no_gaps;
	bit   hold_req;
	int   cycles;

	logic [7:0] pat_set [7]  = '{8'h61, 8'h62, 8'h63, 8'h41, 8'h42, 8'h3F, 8'h2A};
	logic [7:0] text_set [6] = '{8'h61, 8'h62, 8'h63, 8'h41, 8'h42, 8'h43};

	wsam_in_if  in_ch();
	wsam_out_if out_ch();

	wildcard_shift_and_matcher u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	wsam_match_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#10 clk = ~clk;
		end
	end

	// Offer one item and wait for it to be taken; bursts end with a random gap unless no_gaps is set.
	task automatic push_item(input logic [2:0] c, input logic [7:0] b, input logic [31:0] sp,
		input logic l);
		in_ch.valid          <= 1'b1;
		in_ch.cmd            <= c;
		in_ch.byte_value     <= b;
		in_ch.start_position <= sp;
		in_ch.is_last        <= l;
		@(posedge clk);
		while (!in_ch.ready) begin
			@(posedge clk);
		end
		sent_count++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			if (!no_gaps) begin
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			burst_left = $urandom_range(0, 30);
		end
	endtask

	// receiver: stall pattern changes now and then; one long hold-off on request
	initial begin
		int mode;
		int mode_left;
		int hold_left;
		int tick;
		mode      = 0;
		mode_left = 0;
		hold_left = 0;
		tick      = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(100, 600);
			end else begin
				mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= 1'($urandom_range(0, 1));
					2: out_ch.ready <= ($urandom_range(0, 3) != 0);
					default: out_ch.ready <= ((tick % 7) >= 3);
				endcase
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("wildcard_shift_and_matcher_test: FAIL");
		$finish;
	end

	initial begin
		int          r;
		int          plen;
		int          tlen;
		int          nsearch;
		logic [7:0]  b;
		logic [31:0] sp;
		bit          drop_last;
		sent_count = 0;
		burst_left = 0;
		no_gaps    = 1'b0;
		hold_req   = 1'b0;
		arst_n     = 1'b0;
		in_ch.valid          <= 1'b0;
		in_ch.cmd            <= CMD_BEGIN_PAT;
		in_ch.byte_value     <= '0;
		in_ch.start_position <= '0;
		in_ch.is_last        <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: literals with case folding, star, question mark, wrap of positions
		push_item(CMD_BEGIN_PAT, 8'h00, 32'h0, 1'b0);
		push_item(CMD_PAT_BYTE, 8'h41, 32'h0, 1'b0);
		push_item(CMD_PAT_BYTE, STAR_BYTE, 32'h0, 1'b0);
		push_item(CMD_PAT_BYTE, QMARK_BYTE, 32'h0, 1'b0);
		push_item(CMD_PAT_BYTE, 8'h7A, 32'h0, 1'b0);
		push_item(CMD_END_PAT, 8'h00, 32'h0, 1'b0);
		push_item(CMD_TEXT, 8'h61, 32'h0, 1'b1);             // no search active
		push_item(CMD_BEGIN_SEARCH, 8'h00, 32'hFFFF_FFFE, 1'b0);
		push_item(CMD_TEXT, 8'h78, 32'h0, 1'b0);
		push_item(CMD_TEXT, 8'h61, 32'h0, 1'b0);
		push_item(CMD_TEXT, 8'hFF, 32'h0, 1'b0);
		push_item(CMD_TEXT, 8'h5A, 32'h0, 1'b1);
		push_item(CMD_BEGIN_SEARCH, 8'hFF, 32'h0, 1'b1);
		push_item(CMD_TEXT, 8'h62, 32'h0, 1'b1);             // not found
		push_item(CMD_UNUSED_LO, 8'hFF, 32'hFFFF_FFFF, 1'b1);
		push_item(CMD_UNUSED_HI, 8'h00, 32'h0, 1'b0);
		// empty pattern never matches
		push_item(CMD_BEGIN_PAT, 8'hFF, 32'hFFFF_FFFF, 1'b1);
		push_item(CMD_END_PAT, 8'h00, 32'h0, 1'b0);
		push_item(CMD_BEGIN_SEARCH, 8'h00, 32'hFFFF_FFFF, 1'b0);
		push_item(CMD_TEXT, 8'h71, 32'h0, 1'b1);
		// byte zero as a literal, a pattern byte after end pattern, match on the last byte
		push_item(CMD_BEGIN_PAT, 8'h00, 32'h0, 1'b0);
		push_item(CMD_PAT_BYTE, 8'h00, 32'h0, 1'b0);
		push_item(CMD_END_PAT, 8'h00, 32'h0, 1'b0);
		push_item(CMD_PAT_BYTE, 8'h00, 32'h0, 1'b0);
		push_item(CMD_BEGIN_SEARCH, 8'h00, 32'h7, 1'b0);
		push_item(CMD_TEXT, 8'h00, 32'h0, 1'b1);

		// back-pressure: hold the receiver while single-byte matches pile up
		no_gaps  = 1'b1;
		hold_req = 1'b1;
		push_item(CMD_BEGIN_PAT, 8'h00, 32'h0, 1'b0);
		push_item(CMD_PAT_BYTE, QMARK_BYTE, 32'h0, 1'b0);
		push_item(CMD_END_PAT, 8'h00, 32'h0, 1'b0);
		repeat (40) begin
			push_item(CMD_BEGIN_SEARCH, 8'h00, $urandom, 1'b0);
			push_item(CMD_TEXT, 8'($urandom_range(0, 255)), 32'h0, 1'b1);
		end

		while (sent_count < ITEM_TARGET) begin
			r       = $urandom_range(0, 99);
			no_gaps = ($urandom_range(0, 4) == 0);
			if (r < 10) begin
				repeat ($urandom_range(1, 5)) begin
					push_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), $urandom,
						1'($urandom_range(0, 1)));
				end
			end else begin
				push_item(CMD_BEGIN_PAT, 8'($urandom_range(0, 255)), $urandom,
					1'($urandom_range(0, 1)));
				r = $urandom_range(0, 99);
				if (r < 7) begin
					plen = 0;
				end else if (r < 10) begin
					plen = $urandom_range(60, 72);
				end else begin
					plen = $urandom_range(1, 8);
				end
				for (int k = 0; k < plen; k++) begin
					b = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
						: pat_set[$urandom_range(0, 6)];
					push_item(CMD_PAT_BYTE, b, $urandom, 1'($urandom_range(0, 1)));
				end
				if ($urandom_range(0, 9) != 0) begin
					push_item(CMD_END_PAT, 8'($urandom_range(0, 255)), $urandom,
						1'($urandom_range(0, 1)));
				end
				nsearch = $urandom_range(1, 3);
				repeat (nsearch) begin
					r = $urandom_range(0, 3);
					if (r == 0) begin
						sp = 32'hFFFF_FFFF - $urandom_range(0, 10);
					end else if (r == 1) begin
						sp = $urandom;
					end else begin
						sp = $urandom_range(0, 1000);
					end
					push_item(CMD_BEGIN_SEARCH, 8'($urandom_range(0, 255)), sp,
						1'($urandom_range(0, 1)));
					tlen = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 80)
						: $urandom_range(1, 16);
					drop_last = ($urandom_range(0, 9) == 0);
					for (int j = 0; j < tlen; j++) begin
						b = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
							: text_set[$urandom_range(0, 5)];
						push_item(CMD_TEXT, b, $urandom, (j == tlen - 1) && !drop_last);
					end
					if (drop_last && $urandom_range(0, 1) == 0) begin
						// pattern byte mid-search ends the search
						push_item(CMD_PAT_BYTE, pat_set[$urandom_range(0, 6)], $urandom, 1'b0);
					end
				end
			end
		end

		if (burst_left > 0 || no_gaps) begin
			in_ch.valid <= 1'b0;
		end
		// let the checker record the last accepted item first
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("wildcard_shift_and_matcher_test: PASS");
		end else begin
			$display("wildcard_shift_and_matcher_test: FAIL");
		end
		$finish;
	end

endmodule
